// File: rtl/tks_pkg.sv
`default_nettype none
package tks_pkg;
   localparam int KEEP_DEPTH = 64;
   localparam int ADDR_W = $clog2(KEEP_DEPTH);
   localparam int CNT_W = $clog2(KEEP_DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int PICK_W = 7;
   localparam int COST_W = 31;
   localparam int DAY_W = 32;
   localparam int SUM_W = 40;
   localparam int BEST_W = 63;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PICK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_COST = 1'd1;

   typedef struct packed {
      logic ld_item;
      logic calc_cost;
      logic decide;
      logic offer_sub;
      logic offer_cmp;
      logic scan_rd;
      logic scan_cmp;
      logic repl;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scored;
      logic need_scan;
      logic scan_last;
      logic rsp_free;
   } status_type;
endpackage
`default_nettype wire

// File: rtl/tks_ifs.sv
`default_nettype none
interface tks_req_if;
   logic valid;
   logic ready;
   logic signed [tks_pkg::VALUE_W-1:0] value;
   logic first;
   modport source (output valid, value, first, input ready);
   modport sink (input valid, value, first, output ready);
endinterface

interface tks_rsp_if;
   logic valid;
   logic ready;
   logic [tks_pkg::BEST_W-1:0] best_score;
   modport source (output valid, best_score, input ready);
   modport sink (input valid, best_score, output ready);
endinterface

interface tks_csr_if;
   logic valid;
   logic ready;
   logic [tks_pkg::CSR_IDX_W-1:0] index;
   logic [tks_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/tks_ram.sv
`default_nettype none
module tks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(DEPTH)-1:0] waddr,
   input wire logic [WIDTH-1:0] wdata,
   input wire logic re,
   input wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/tks_ctrl.sv
`default_nettype none
module tks_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire tks_pkg::status_type status,
   output tks_pkg::cmd_type cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_COST = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_SUB = 4'd3;
   localparam logic [3:0] S_CMP = 4'd4;
   localparam logic [3:0] S_SCAN_RD = 4'd5;
   localparam logic [3:0] S_SCAN_CMP = 4'd6;
   localparam logic [3:0] S_REPL = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld_item = 1'b1;
               state_in = S_COST;
            end
         end
         S_COST: begin
            cmd.calc_cost = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = S_SUB;
         end
         S_SUB: begin
            if (status.scored) begin
               cmd.offer_sub = 1'b1;
               state_in = S_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CMP: begin
            cmd.offer_cmp = 1'b1;
            state_in = status.need_scan ? S_SCAN_RD : S_DONE;
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in = status.scan_last ? S_REPL : S_SCAN_RD;
         end
         S_REPL: begin
            cmd.repl = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_scan_needs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_RD) |-> status.need_scan)
      else $error("scan without full store");
   a_scan_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_RD) |=> (state_ff == S_SCAN_CMP))
      else $error("scan read not followed by compare");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_item |=> !req_ready)
      else $error("ready during item work");
endmodule
`default_nettype wire

// File: rtl/tks_dp.sv
`default_nettype none
module tks_dp (
   input wire logic clock,
   input wire logic reset,
   input wire tks_pkg::cmd_type cmd,
   output tks_pkg::status_type status,
   input wire logic signed [tks_pkg::VALUE_W-1:0] req_value,
   input wire logic req_first,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [tks_pkg::BEST_W-1:0] rsp_best_score,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [tks_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [tks_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam logic [tks_pkg::DAY_W-1:0] DAY_MAX = '1;
   localparam logic [tks_pkg::CNT_W-1:0] DEPTH_CNT = tks_pkg::CNT_W'(tks_pkg::KEEP_DEPTH);

   logic [tks_pkg::PICK_W-1:0] max_pick_ff;
   logic [tks_pkg::COST_W-1:0] day_cost_ff;
   logic [tks_pkg::VALUE_W-1:0] value_ff;
   logic [tks_pkg::DAY_W-1:0] day_ff, day_in;
   logic [tks_pkg::CNT_W-1:0] count_ff;
   logic [tks_pkg::SUM_W-1:0] sum_ff;
   logic [tks_pkg::BEST_W-1:0] best_ff;
   logic [tks_pkg::BEST_W-1:0] cost_ff;
   logic [tks_pkg::SUM_W-1:0] gain_ff;
   logic [tks_pkg::BEST_W-1:0] diff_ff;
   logic dpos_ff, scored_ff, need_scan_ff;
   logic [tks_pkg::ADDR_W-1:0] idx_ff, at_ff;
   logic [tks_pkg::VALUE_W-1:0] min_ff;
   logic rsp_valid_ff;
   logic [tks_pkg::BEST_W-1:0] rsp_best_ff;

   logic positive;
   logic [tks_pkg::PICK_W-1:0] pick_m1, cap;
   logic [tks_pkg::SUM_W-1:0] v_ext;
   logic [tks_pkg::BEST_W:0] sub_full;
   logic ram_we;
   logic [tks_pkg::ADDR_W-1:0] ram_waddr;
   logic [tks_pkg::VALUE_W-1:0] ram_rdata;
   logic insert;

   assign csr_ready = 1'b1;
   assign positive = (value_ff != '0) && !value_ff[tks_pkg::VALUE_W-1];
   assign pick_m1 = max_pick_ff - 1'b1;
   assign cap = (pick_m1 > DEPTH_CNT) ? DEPTH_CNT : pick_m1;
   assign v_ext = tks_pkg::SUM_W'(value_ff);
   assign sub_full = {(tks_pkg::BEST_W + 1 - tks_pkg::SUM_W)'(0), gain_ff} - {1'b0, cost_ff};
   assign insert = cmd.decide && (max_pick_ff != '0) && positive && (max_pick_ff != 7'd1)
      && (count_ff < cap);

   always_comb begin
      day_in = req_first ? '0 : day_ff;
      if (day_in != DAY_MAX) begin
         day_in = day_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pick_ff <= tks_pkg::PICK_W'(1);
         day_cost_ff <= '0;
         day_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         best_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               tks_pkg::CSR_MAX_PICK: max_pick_ff <= csr_data[tks_pkg::PICK_W-1:0];
               tks_pkg::CSR_DAY_COST: day_cost_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.ld_item) begin
            day_ff <= day_in;
            if (req_first) begin
               count_ff <= '0;
               sum_ff <= '0;
               best_ff <= '0;
            end
         end
         if (insert) begin
            count_ff <= count_ff + 1'b1;
            sum_ff <= sum_ff + v_ext;
         end
         if (cmd.offer_cmp && dpos_ff && (diff_ff > best_ff)) begin
            best_ff <= diff_ff;
         end
         if (cmd.repl && ($signed(value_ff) > $signed(min_ff))) begin
            sum_ff <= sum_ff - tks_pkg::SUM_W'(min_ff) + v_ext;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_item) begin
         value_ff <= req_value;
      end
      if (cmd.calc_cost) begin
         cost_ff <= tks_pkg::BEST_W'(day_cost_ff) * tks_pkg::BEST_W'(day_ff);
      end
      if (cmd.decide) begin
         scored_ff <= (max_pick_ff != '0) && positive;
         if (max_pick_ff == 7'd1) begin
            gain_ff <= v_ext;
            need_scan_ff <= 1'b0;
         end else begin
            gain_ff <= sum_ff + v_ext;
            need_scan_ff <= (count_ff >= cap) && (count_ff != '0);
         end
      end
      if (cmd.offer_sub) begin
         diff_ff <= sub_full[tks_pkg::BEST_W-1:0];
         dpos_ff <= !sub_full[tks_pkg::BEST_W] && (sub_full != '0);
      end
      if (cmd.offer_cmp) begin
         idx_ff <= '0;
      end
      if (cmd.scan_cmp) begin
         if ((idx_ff == '0) || ($signed(ram_rdata) < $signed(min_ff))) begin
            min_ff <= ram_rdata;
            at_ff <= idx_ff;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.out_load) begin
         rsp_best_ff <= best_ff;
      end
   end

   assign ram_we = insert || (cmd.repl && ($signed(value_ff) > $signed(min_ff)));
   assign ram_waddr = insert ? count_ff[tks_pkg::ADDR_W-1:0] : at_ff;

   tks_ram #(
      .WIDTH(tks_pkg::VALUE_W),
      .DEPTH(tks_pkg::KEEP_DEPTH)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(value_ff),
      .re(cmd.scan_rd),
      .raddr(idx_ff),
      .rdata(ram_rdata)
   );

   assign status.scored = scored_ff;
   assign status.need_scan = need_scan_ff;
   assign status.scan_last = (tks_pkg::CNT_W'(idx_ff) + 1'b1) == count_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_best_score = rsp_best_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("kept count above depth");
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0))
      else $error("sum nonzero with empty store");
   a_best_mono: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ld_item && req_first) |=> (best_ff >= $past(best_ff)))
      else $error("best score decreased");
endmodule
`default_nettype wire

// File: rtl/streaming_top_k_sum_best_score_unit.sv
`default_nettype none
// channel   dir  handshake             payload
// req_ch    in   valid/ready           value (s32), first
// rsp_ch    out  valid/ready           best_score (u63)
// csr_ch    in   valid/ready (always)  index (0 max_pick, 1 day_cost), data
//
// one request walks load, cost, decide and the sub step, then when scored the
// offer compare and, when the store is full, a min search that reads the store
// one entry at a time (a read, then a compare) and a replacement, then output load
// the 31x32 day cost multiply and the 63-bit subtract are each registered
// synchronous active-high reset; store contents are undefined, count clears
// the result sits in an output register; the next request is taken while it
// waits, and only the final load stalls on a still-full output register
module streaming_top_k_sum_best_score_unit (
   input wire logic clock,
   input wire logic reset,
   tks_req_if.sink req_ch,
   tks_rsp_if.source rsp_ch,
   tks_csr_if.sink csr_ch
);
   tks_pkg::cmd_type cmd;
   tks_pkg::status_type status;

   // sequencer: walks each request through cost, then offer when scored and min scan when the store is full
   tks_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .status(status),
      .cmd(cmd)
   );

   // registers, kept-value store, multiplier and compare logic
   tks_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_value(req_ch.value),
      .req_first(req_ch.first),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_best_score(rsp_ch.best_score),
      .csr_valid(csr_ch.valid),
      .csr_ready(csr_ch.ready),
      .csr_index(csr_ch.index),
      .csr_data(csr_ch.data)
   );
endmodule
`default_nettype wire
